>>> hdl/bdlpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlpr_pkg
// Shared types and codes for the debounced button with long press and repeat.
// ----------------------------------------------------------------------------
package bdlpr_pkg;

   // button state codes, as seen on the result word
   localparam logic [1:0] ST_IDLE       = 2'd0;
   localparam logic [1:0] ST_DEBOUNCING = 2'd1;
   localparam logic [1:0] ST_PRESSED    = 2'd2;
   localparam logic [1:0] ST_HELD       = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LOW      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TIME   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TIME = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 8'd3;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   typedef struct packed {
      logic        active_low;
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] repeat_interval;
   } cfg_type;

   // lowest bit last: state in bits 1:0, repeat_event in bit 6
   typedef struct packed {
      logic       repeat_event;
      logic       long_press_event;
      logic       release_event;
      logic       press_event;
      logic       is_pressed;
      logic [1:0] button_state;
   } result_type;

endpackage

>>> hdl/bdlpr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlpr_csr
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bdlpr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdlpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdlpr_pkg::CSR_DATA_W-1:0]     csr_data,
   output bdlpr_pkg::cfg_type                   cfg
);

   bdlpr_pkg::cfg_type cfg_ff;
   bdlpr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bdlpr_pkg::CSR_ACTIVE_LOW:      cfg_in.active_low      = csr_data[0];
            bdlpr_pkg::CSR_DEBOUNCE_TIME:   cfg_in.debounce_time   = csr_data;
            bdlpr_pkg::CSR_LONG_PRESS_TIME: cfg_in.long_press_time = csr_data;
            bdlpr_pkg::CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low      <= 1'b1;
         cfg_ff.debounce_time   <= 16'd20;
         cfg_ff.long_press_time <= 16'd0;
         cfg_ff.repeat_interval <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/bdlpr_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlpr_fsm
// Button state machine and time stamps; one step per enabled cycle.
// ----------------------------------------------------------------------------
module bdlpr_fsm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic                              raw_level,
   input  logic [bdlpr_pkg::TIME_W-1:0]      now_ms,
   input  bdlpr_pkg::cfg_type                cfg,
   output bdlpr_pkg::result_type             result
);

   typedef enum logic [1:0] {
      S_IDLE       = bdlpr_pkg::ST_IDLE,
      S_DEBOUNCING = bdlpr_pkg::ST_DEBOUNCING,
      S_PRESSED    = bdlpr_pkg::ST_PRESSED,
      S_HELD       = bdlpr_pkg::ST_HELD
   } state_type;

   state_type                     state_ff, state_in;
   logic [bdlpr_pkg::TIME_W-1:0]  start_ff, start_in;
   logic [bdlpr_pkg::TIME_W-1:0]  rpt_start_ff, rpt_start_in;

   logic                          active;
   logic [bdlpr_pkg::TIME_W-1:0]  elapsed;
   logic [bdlpr_pkg::TIME_W-1:0]  rpt_elapsed;
   logic                          ev_press, ev_release, ev_long, ev_repeat;

   assign active      = cfg.active_low ? ~raw_level : raw_level;
   assign elapsed     = now_ms - start_ff;
   assign rpt_elapsed = now_ms - rpt_start_ff;

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      rpt_start_in = rpt_start_ff;
      ev_press     = 1'b0;
      ev_release   = 1'b0;
      ev_long      = 1'b0;
      ev_repeat    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (active) begin
               state_in = S_DEBOUNCING;
               start_in = now_ms;
            end
         end
         S_DEBOUNCING: begin
            if (!active) begin
               state_in = S_IDLE;
               start_in = now_ms;
            end else if (elapsed >= {16'd0, cfg.debounce_time}) begin
               state_in     = S_PRESSED;
               start_in     = now_ms;
               rpt_start_in = now_ms;
               ev_press     = 1'b1;
            end
         end
         S_PRESSED, S_HELD: begin
            if (!active) begin
               state_in   = S_IDLE;
               start_in   = now_ms;
               ev_release = 1'b1;
            end else if (state_ff == S_PRESSED && cfg.long_press_time != 16'd0 &&
                         elapsed >= {16'd0, cfg.long_press_time}) begin
               // repeat stamp restarts here, so repeat cannot fire this step
               state_in     = S_HELD;
               start_in     = now_ms;
               rpt_start_in = now_ms;
               ev_long      = 1'b1;
            end else if (cfg.repeat_interval != 16'd0 &&
                         rpt_elapsed >= {16'd0, cfg.repeat_interval}) begin
               rpt_start_in = now_ms;
               ev_repeat    = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      result.button_state     = state_in;
      result.is_pressed       = state_in[1];
      result.press_event      = ev_press;
      result.release_event    = ev_release;
      result.long_press_event = ev_long;
      result.repeat_event     = ev_repeat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         rpt_start_ff <= '0;
      end else if (step_en) begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rpt_start_ff <= rpt_start_in;
      end
   end

endmodule

>>> hdl/button_debounce_long_press_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// Debounced push button with press, release, long-press and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one poll word per button sample, carrying the raw pin
//    level and a wrapping millisecond timestamp.
//  - rsp_ channel: exactly one result word per poll, in order, with the
//    state after the poll and the event pulses it raised.
//  - csr_ channel: register writes (0 active_low, 1 debounce_time,
//    2 long_press_time, 3 repeat_interval); always ready, only to be used
//    while no poll is in flight. Unknown indexes are dropped.
//  - Path: an accepted poll goes into the input register; when that poll
//    steps the machine, its result goes into the result register.
//  - Throughput: one poll per cycle while rsp_tready is high; the state
//    step is a pair of 32-bit subtract-and-compare paths plus the state update.
//  - Reset: state idle, stamps zero, registers at their defaults
//    (active low, 20 ms debounce, long press and repeat off).
//  - Stall: rsp_tready held low keeps the result word stable; one further
//    poll waits in the input register, and req_tready drops only when both
//    registers are full.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat (
   input  logic                                clock,
   input  logic                                reset,
   // poll in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bdlpr_pkg::REQ_DATA_W-1:0]    req_tdata,  // raw_level, now_ms[31:0], pad
   // result out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bdlpr_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // button_state[1:0], is_pressed,
                                                           // press_event, release_event,
                                                           // long_press_event, repeat_event, pad
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdlpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdlpr_pkg::CSR_DATA_W-1:0]    csr_data
);

   bdlpr_pkg::cfg_type            cfg;
   bdlpr_pkg::result_type         step_result;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_level_ff, in_level_in;
   logic [bdlpr_pkg::TIME_W-1:0]  in_now_ff, in_now_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   bdlpr_pkg::result_type         rsp_data_ff, rsp_data_in;

   logic                          advance;
   logic                          req_take;

   // the held poll steps the machine when the result register frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign in_level_in  = req_take ? req_tdata[0] : in_level_ff;
   assign in_now_in    = req_take ? req_tdata[32:1] : in_now_ff;

   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = advance ? step_result : rsp_data_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   bdlpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bdlpr_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .raw_level (in_level_ff),
      .now_ms    (in_now_ff),
      .cfg       (cfg),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_level_ff <= in_level_in;
      in_now_ff   <= in_now_in;
      rsp_data_ff <= rsp_data_in;
   end

   // press confirmation always lands in the pressed state
   a_press_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.press_event) |->
         (rsp_data_ff.button_state == bdlpr_pkg::ST_PRESSED))
      else $error("press event without pressed state");

   // release always returns to idle
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.release_event) |->
         (rsp_data_ff.button_state == bdlpr_pkg::ST_IDLE))
      else $error("release event without idle state");

   // long press restarts the repeat timer, so both never fire together
   a_long_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.long_press_event && rsp_data_ff.repeat_event))
      else $error("long press and repeat in the same word");

   // pressed flag follows the state
   a_pressed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_pressed == rsp_data_ff.button_state[1]))
      else $error("is_pressed disagrees with state");

   // a held poll is never dropped while the result side stalls
   a_hold_poll: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_now_ff)))
      else $error("held poll lost");

endmodule
